// ===== hdl/rle565_pkg.sv =====
// shared types and constants of the rgb565 run-length encoder
package rle565_pkg;

   localparam int PixelW    = 16;
   localparam int CountW    = 16;
   localparam int KindW     = 2;
   localparam int BytesW    = 28;
   localparam int DimW      = 13;
   localparam int CsrIndexW = 2;
   localparam int SeenW     = 24;
   localparam int TotalW    = 2 * DimW;

   localparam logic [DimW-1:0]   DimMax      = DimW'(4096);
   localparam logic [DimW-1:0]   DimMin      = DimW'(1);
   localparam logic [DimW-1:0]   WidthReset  = DimW'(480);
   localparam logic [DimW-1:0]   HeightReset = DimW'(320);
   localparam logic [CountW-1:0] RunLimit    = 16'hffff;

   typedef enum logic [KindW-1:0] {
      KIND_PIXEL = 2'd0,
      KIND_COUNT = 2'd1,
      KIND_TERM  = 2'd2
   } word_kind_type;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1
   } csr_index_type;

   // out-of-range dimension writes: zero becomes one, anything above the max saturates
   function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] d);
      logic [DimW-1:0] r;
      if (d == '0) begin
         r = DimMin;
      end else if (d > DimMax) begin
         r = DimMax;
      end else begin
         r = d;
      end
      return r;
   endfunction

endpackage

// ===== hdl/rle565_if.sv =====
// valid/ready channel interfaces of the rgb565 run-length encoder

interface rle565_pix_if;
   logic                          valid;
   logic                          ready;
   logic [rle565_pkg::PixelW-1:0] pixel_value;

   modport source (output valid, output pixel_value, input ready);
   modport sink   (input valid, input pixel_value, output ready);
endinterface

interface rle565_word_if;
   logic                          valid;
   logic                          ready;
   logic [rle565_pkg::PixelW-1:0] out_word;
   rle565_pkg::word_kind_type     word_kind;
   logic                          last_word;
   logic [rle565_pkg::BytesW-1:0] encoded_bytes;

   modport source (output valid, output out_word, output word_kind, output last_word,
                   output encoded_bytes, input ready);
   modport sink   (input valid, input out_word, input word_kind, input last_word,
                   input encoded_bytes, output ready);
endinterface

interface rle565_csr_if;
   logic                             valid;
   logic                             ready;
   logic [rle565_pkg::CsrIndexW-1:0] index;
   logic [rle565_pkg::DimW-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/rgb565_run_length_encoder.sv =====
// top level of the rgb565 run-length encoder
//
//  channel    dir  payload                                          transfer
//  req_chan   in   pixel_value[15:0]                                valid & ready
//  rsp_chan   out  out_word[15:0] word_kind[1:0] last_word          valid & ready
//                  encoded_bytes[27:0]
//  csr_chan   in   index[1:0] data[12:0]                            valid & ready
//
// a pixel waits in the input register; its words (none to four) are then built
// combinationally into the result register, which drains one word per cycle while
// rsp_chan is ready; the result port sets the sustained rate: one pixel per cycle while runs
// continue and no words are pending; a pixel that has words holds the next pixel in the
// input register until its last word is taken
// reset is synchronous; it clears run state and frame counters and sets dims to 480 x 320
// a stalled result port holds the result register and backs up through the input register
// csr_chan is always ready; writes land on the next edge

module rgb565_run_length_encoder (
   input  logic                 clock,
   input  logic                 reset,
   rle565_pix_if.sink           req_chan,
   rle565_word_if.source        rsp_chan,
   rle565_csr_if.sink           csr_chan
);

   import rle565_pkg::*;

   // configuration
   logic [DimW-1:0] width_ff,  width_in;
   logic [DimW-1:0] height_ff, height_in;

   // input register
   logic              a_valid_ff, a_valid_in;
   logic [PixelW-1:0] a_pixel_ff, a_pixel_in;

   // run state
   logic [PixelW-1:0] run_pixel_ff, run_pixel_in;
   logic [CountW-1:0] run_count_ff, run_count_in;
   logic              run_open_ff,  run_open_in;
   logic [SeenW-1:0]  seen_ff,      seen_in;
   logic [BytesW-1:0] bytes_ff,     bytes_in;

   // result register: slot 0 closing count, 1 new run value, 2 final count, 3 terminator
   logic [3:0]        b_mask_ff,  b_mask_in;
   logic [CountW-1:0] b_close_ff, b_close_in;
   logic [PixelW-1:0] b_value_ff, b_value_in;
   logic [CountW-1:0] b_final_ff, b_final_in;
   logic [BytesW-1:0] b_bytes_ff, b_bytes_in;

   // encode logic
   logic              same;
   logic              sat;
   logic [CountW-1:0] cnt_inc;
   logic              close_en;
   logic              value_en;
   logic              final_en;
   logic              frame_end;
   logic              open_after;
   logic [CountW-1:0] count_after;
   logic [PixelW-1:0] pixel_after;
   logic [SeenW:0]    seen_next;
   logic [TotalW-1:0] total;
   logic [2:0]        n_words;
   logic [BytesW-1:0] bytes_final;

   // handshake
   logic b_empty;
   logic b_one_left;
   logic rsp_fire;
   logic b_load;
   logic req_fire;

   assign b_empty    = (b_mask_ff == 4'b0000);
   assign b_one_left = ((b_mask_ff & (b_mask_ff - 4'd1)) == 4'b0000);
   assign rsp_fire   = rsp_chan.valid && rsp_chan.ready;
   assign b_load     = a_valid_ff && (b_empty || (rsp_fire && b_one_left));
   assign req_fire   = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !a_valid_ff || b_load;
   assign csr_chan.ready = 1'b1;

   // configuration writes, unknown indexes ignored
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_FRAME_WIDTH:  width_in  = clamp_dim(csr_chan.data);
            CSR_FRAME_HEIGHT: height_in = clamp_dim(csr_chan.data);
            default: ;
         endcase
      end
   end

   // input register
   always_comb begin
      a_valid_in = a_valid_ff;
      a_pixel_in = a_pixel_ff;
      if (b_load) begin
         a_valid_in = 1'b0;
      end
      if (req_fire) begin
         a_valid_in = 1'b1;
         a_pixel_in = req_chan.pixel_value;
      end
   end

   // one pixel against the open run
   always_comb begin
      same    = run_open_ff && (a_pixel_ff == run_pixel_ff);
      cnt_inc = run_count_ff + CountW'(1);
      sat     = same && (cnt_inc == RunLimit);

      // a differing pixel closes the open run; a saturated run closes at the limit
      close_en = same ? sat : run_open_ff;
      value_en = !same;

      open_after  = same ? !sat : 1'b1;
      count_after = same ? (sat ? '0 : cnt_inc) : CountW'(1);
      pixel_after = same ? run_pixel_ff : a_pixel_ff;

      total     = TotalW'(width_ff) * TotalW'(height_ff);
      seen_next = {1'b0, seen_ff} + (SeenW+1)'(1);
      frame_end = (TotalW'(seen_next) >= total);
      final_en  = frame_end && open_after;

      n_words = 3'(close_en) + 3'(value_en) + 3'(final_en) + 3'(frame_end);
      // two bytes per word, terminator included
      bytes_final = bytes_ff + BytesW'({n_words, 1'b0});
   end

   // state update and result register load
   always_comb begin
      run_pixel_in = run_pixel_ff;
      run_count_in = run_count_ff;
      run_open_in  = run_open_ff;
      seen_in      = seen_ff;
      bytes_in     = bytes_ff;
      b_mask_in    = b_mask_ff;
      b_close_in   = b_close_ff;
      b_value_in   = b_value_ff;
      b_final_in   = b_final_ff;
      b_bytes_in   = b_bytes_ff;

      // drop the word just taken
      if (rsp_fire) begin
         b_mask_in = b_mask_ff & (b_mask_ff - 4'd1);
      end

      if (b_load) begin
         b_mask_in  = {frame_end, final_en, value_en, close_en};
         b_close_in = same ? RunLimit : run_count_ff;
         b_value_in = a_pixel_ff;
         b_final_in = count_after;
         b_bytes_in = bytes_final;
         if (frame_end) begin
            // next frame starts clean
            run_pixel_in = '0;
            run_count_in = '0;
            run_open_in  = 1'b0;
            seen_in      = '0;
            bytes_in     = '0;
         end else begin
            run_pixel_in = pixel_after;
            run_count_in = count_after;
            run_open_in  = open_after;
            seen_in      = seen_next[SeenW-1:0];
            bytes_in     = bytes_final;
         end
      end
   end

   // output word is the lowest pending slot
   always_comb begin
      rsp_chan.valid         = !b_empty;
      rsp_chan.out_word      = '0;
      rsp_chan.word_kind     = KIND_TERM;
      rsp_chan.last_word     = 1'b0;
      rsp_chan.encoded_bytes = '0;
      if (b_mask_ff[0]) begin
         rsp_chan.out_word  = b_close_ff;
         rsp_chan.word_kind = KIND_COUNT;
      end else if (b_mask_ff[1]) begin
         rsp_chan.out_word  = b_value_ff;
         rsp_chan.word_kind = KIND_PIXEL;
      end else if (b_mask_ff[2]) begin
         rsp_chan.out_word  = b_final_ff;
         rsp_chan.word_kind = KIND_COUNT;
      end else if (b_mask_ff[3]) begin
         rsp_chan.last_word     = 1'b1;
         rsp_chan.encoded_bytes = b_bytes_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WidthReset;
         height_ff    <= HeightReset;
         a_valid_ff   <= 1'b0;
         b_mask_ff    <= '0;
         run_pixel_ff <= '0;
         run_count_ff <= '0;
         run_open_ff  <= 1'b0;
         seen_ff      <= '0;
         bytes_ff     <= '0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         a_valid_ff   <= a_valid_in;
         b_mask_ff    <= b_mask_in;
         run_pixel_ff <= run_pixel_in;
         run_count_ff <= run_count_in;
         run_open_ff  <= run_open_in;
         seen_ff      <= seen_in;
         bytes_ff     <= bytes_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      a_pixel_ff <= a_pixel_in;
      b_close_ff <= b_close_in;
      b_value_ff <= b_value_in;
      b_final_ff <= b_final_in;
      b_bytes_ff <= b_bytes_in;
   end

endmodule

// ===== verif/tb_rgb565_run_length_encoder.sv =====
// self-checking testbench of the rgb565 run-length encoder: directed table, random frames
module tb_rgb565_run_length_encoder;
   timeunit 1ns;
   timeprecision 1ps;

   import rle565_pkg::*;

   localparam int unsigned CycleLimit   = 100_000;
   localparam int unsigned HoldCycles   = 150;  // long receiver hold-off
   localparam int unsigned SettleCycles = 6;    // input register plus word build, with margin
   localparam int unsigned RandPerPhase = 33;

   // indexes with no register behind them
   localparam logic [CsrIndexW-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CsrIndexW-1:0] CSR_SPARE_3 = 2'd3;

   // idle and stall odds per random phase, in percent
   localparam int unsigned PhaseSrcIdle  [4] = '{0, 62, 0, 29};
   localparam int unsigned PhaseSinkStall[4] = '{0, 0, 62, 29};

   typedef struct packed {
      logic [PixelW-1:0] word;
      word_kind_type     kind;
      logic              last;
      logic [BytesW-1:0] bytes;
   } enc_word_type;

   typedef enum logic {
      ROW_PIXEL,
      ROW_CSR
   } row_op_type;

   // one row of the directed table; typed words replace the prediction where n_typed is set
   typedef struct packed {
      row_op_type           op;
      logic [CsrIndexW-1:0] idx;
      logic [DimW-1:0]      data;
      logic [PixelW-1:0]    pix;
      logic [1:0]           n_typed;
      enc_word_type         w0;
      enc_word_type         w1;
      enc_word_type         w2;
   } stim_row_type;

   localparam enc_word_type NO_WORD  = '0;
   localparam enc_word_type ONE_RUN  = '{16'd1, KIND_COUNT, 1'b0, 28'd0};
   localparam enc_word_type TERM_SIX = '{16'd0, KIND_TERM, 1'b1, 28'd6};

   localparam int DirRows = 28;

   stim_row_type dir_table [DirRows] = '{
      // first pixel after reset, all ones: value only, no count in front
      '{ROW_PIXEL, CSR_FRAME_WIDTH, 13'd0, 16'hffff, 2'd1,
        '{16'hffff, KIND_PIXEL, 1'b0, 28'd0}, NO_WORD, NO_WORD},
      '{ROW_PIXEL, CSR_FRAME_WIDTH, 13'd0, 16'hffff, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_PIXEL, CSR_FRAME_WIDTH, 13'd0, 16'h0000, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      // shrink the frame mid-way, height zero taken as one
      '{ROW_CSR, CSR_FRAME_WIDTH, 13'd1, 16'h0000, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_CSR, CSR_FRAME_HEIGHT, 13'd0, 16'h0000, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_PIXEL, CSR_FRAME_WIDTH, 13'd0, 16'h0000, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      // one-pixel frames: value, count of one, terminator of six bytes
      '{ROW_PIXEL, CSR_FRAME_WIDTH, 13'd0, 16'h0000, 2'd3,
        '{16'h0000, KIND_PIXEL, 1'b0, 28'd0}, ONE_RUN, TERM_SIX},
      '{ROW_PIXEL, CSR_FRAME_WIDTH, 13'd0, 16'hffff, 2'd3,
        '{16'hffff, KIND_PIXEL, 1'b0, 28'd0}, ONE_RUN, TERM_SIX},
      // writes to spare indexes leave the frame size alone
      '{ROW_CSR, CSR_SPARE_3, 13'h1fff, 16'h0000, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_CSR, CSR_SPARE_2, 13'd0, 16'h0000, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_PIXEL, CSR_FRAME_WIDTH, 13'd0, 16'h5555, 2'd3,
        '{16'h5555, KIND_PIXEL, 1'b0, 28'd0}, ONE_RUN, TERM_SIX},
      // width all ones saturates at 4096
      '{ROW_CSR, CSR_FRAME_WIDTH, 13'h1fff, 16'h0000, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_PIXEL, CSR_FRAME_WIDTH, 13'd0, 16'haaaa, 2'd1,
        '{16'haaaa, KIND_PIXEL, 1'b0, 28'd0}, NO_WORD, NO_WORD},
      '{ROW_PIXEL, CSR_FRAME_WIDTH, 13'd0, 16'haaaa, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_PIXEL, CSR_FRAME_WIDTH, 13'd0, 16'h5555, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      // 2 x 2 written after three pixels: the next pixel closes the frame
      '{ROW_CSR, CSR_FRAME_WIDTH, 13'd2, 16'h0000, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_CSR, CSR_FRAME_HEIGHT, 13'd2, 16'h0000, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_PIXEL, CSR_FRAME_WIDTH, 13'd0, 16'h5555, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      // one column, height just above the max
      '{ROW_CSR, CSR_FRAME_WIDTH, 13'd1, 16'h0000, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_CSR, CSR_FRAME_HEIGHT, 13'd4097, 16'h0000, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_PIXEL, CSR_FRAME_WIDTH, 13'd0, 16'h0f0f, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_PIXEL, CSR_FRAME_WIDTH, 13'd0, 16'h0f0f, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      // grow back to 3 x 2 mid-frame and finish it cleanly
      '{ROW_CSR, CSR_FRAME_WIDTH, 13'd3, 16'h0000, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_CSR, CSR_FRAME_HEIGHT, 13'd2, 16'h0000, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_PIXEL, CSR_FRAME_WIDTH, 13'd0, 16'hf0f0, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_PIXEL, CSR_FRAME_WIDTH, 13'd0, 16'hf0f0, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_PIXEL, CSR_FRAME_WIDTH, 13'd0, 16'h0f0f, 2'd0, NO_WORD, NO_WORD, NO_WORD},
      '{ROW_PIXEL, CSR_FRAME_WIDTH, 13'd0, 16'h0f0f, 2'd0, NO_WORD, NO_WORD, NO_WORD}
   };

   logic clock = 1'b0;
   logic reset;

   rle565_pix_if  req_if ();
   rle565_word_if rsp_if ();
   rle565_csr_if  csr_if ();

   rgb565_run_length_encoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #5 clock = ~clock;

   // encoder shadow: open run, frame position, bytes so far, frame size
   logic [PixelW-1:0] cur_pixel;
   logic [CountW-1:0] cur_len;
   logic              cur_active;
   logic [SeenW-1:0]  frame_pos;
   logic [BytesW-1:0] frame_bytes;
   logic [DimW-1:0]   dim_w;
   logic [DimW-1:0]   dim_h;

   enc_word_type enc_expected [$];  // words still owed by the encoder, oldest first
   int           errors = 0;
   int           last_pred_n;
   int unsigned  src_idle_pct = 0;
   int unsigned  sink_stall_pct = 0;
   int unsigned  hold_grants = 0;     // bumped to ask the receiver for a long hold-off
   int unsigned  cycle_count = 0;

   // queue one plain word and count its two bytes
   function automatic void push_word(input logic [PixelW-1:0] w, input word_kind_type k);
      frame_bytes = frame_bytes + BytesW'(2);
      enc_expected.push_back('{w, k, 1'b0, BytesW'(0)});
   endfunction

   // words caused by one accepted pixel; returns how many were queued
   function automatic int encode_pixel(input logic [PixelW-1:0] pix);
      logic [TotalW-1:0] frame_total;
      logic [SeenW:0]    next_pos;
      int                n;
      n = 0;
      frame_total = TotalW'(dim_w) * TotalW'(dim_h);
      if (cur_active && pix == cur_pixel) begin
         cur_len = cur_len + CountW'(1);
         // a full run goes out at once and the next pixel starts afresh
         if (cur_len == RunLimit) begin
            push_word(RunLimit, KIND_COUNT);
            n++;
            cur_active = 1'b0;
            cur_len = '0;
         end
      end else begin
         if (cur_active) begin
            push_word(cur_len, KIND_COUNT);
            n++;
         end
         push_word(pix, KIND_PIXEL);
         n++;
         cur_pixel = pix;
         cur_len = CountW'(1);
         cur_active = 1'b1;
      end
      next_pos = {1'b0, frame_pos} + (SeenW+1)'(1);
      // frame done once the position reaches or passes the current size
      if (next_pos >= frame_total) begin
         if (cur_active) begin
            push_word(cur_len, KIND_COUNT);
            n++;
         end
         frame_bytes = frame_bytes + BytesW'(2);
         enc_expected.push_back('{PixelW'(0), KIND_TERM, 1'b1, frame_bytes});
         n++;
         cur_pixel = '0;
         cur_len = '0;
         cur_active = 1'b0;
         frame_pos = '0;
         frame_bytes = '0;
      end else begin
         frame_pos = next_pos[SeenW-1:0];
      end
      return n;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endfunction

   // entered and left at a falling edge; valid stays up when the next pixel follows at once
   task automatic send_pixel(input logic [PixelW-1:0] pix);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.pixel_value <= pix;
      do @(posedge clock); while (!req_if.ready);
      last_pred_n = encode_pixel(pix);
      @(negedge clock);
   endtask

   // stop offering, wait for every owed word, then let a pixel in flight finish
   task automatic settle_idle();
      req_if.valid <= 1'b0;
      while (enc_expected.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   // register write while the encoder is quiet; the shadow takes the clamped value
   task automatic csr_write(input logic [CsrIndexW-1:0] idx, input logic [DimW-1:0] val);
      logic [DimW-1:0] dim;
      settle_idle();
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= val;
      do @(posedge clock); while (!csr_if.ready);
      // zero reads as one, anything past the max as the max
      dim = (val == '0) ? DimMin : (val > DimMax) ? DimMax : val;
      case (idx)
         CSR_FRAME_WIDTH: begin
            dim_w = dim;
         end
         CSR_FRAME_HEIGHT: begin
            dim_h = dim;
         end
         default: begin
            // spare index, nothing changes
         end
      endcase
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // receiver: random stalls, plus a long hold-off whenever one is asked for
   initial begin : rsp_sink
      int unsigned hold_left;
      int unsigned grants_seen;
      hold_left = 0;
      grants_seen = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_grants != grants_seen) begin
            grants_seen = hold_grants;
            hold_left = HoldCycles;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
         end
      end
   end

   // every word transfer is matched against the oldest owed word
   always @(posedge clock) begin : rsp_check
      enc_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (enc_expected.size() == 0) begin
            $display("%0t: word %h kind %0d arrived with nothing expected", $time,
                     rsp_if.out_word, rsp_if.word_kind);
            errors++;
         end else begin
            want = enc_expected.pop_front();
            check_field("out_word", want.word, rsp_if.out_word);
            check_field("word_kind", want.kind, rsp_if.word_kind);
            check_field("last_word", want.last, rsp_if.last_word);
            check_field("encoded_bytes", want.bytes, rsp_if.encoded_bytes);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("tb_rgb565_run_length_encoder: FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      enc_word_type      typed [3];
      logic [PixelW-1:0] prev_pix;
      logic [PixelW-1:0] pix;
      int unsigned       roll;

      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.pixel_value <= '0;
      csr_if.valid <= 1'b0;
      csr_if.index <= CSR_FRAME_WIDTH;
      csr_if.data <= '0;
      prev_pix = '0;

      // synchronous reset, released on a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      dim_w = WidthReset;
      dim_h = HeightReset;
      cur_pixel = '0;
      cur_len = '0;
      cur_active = 1'b0;
      frame_pos = '0;
      frame_bytes = '0;

      // directed table, no idling on either side
      for (int i = 0; i < DirRows; i++) begin
         if (dir_table[i].op == ROW_CSR) begin
            csr_write(dir_table[i].idx, dir_table[i].data);
         end else begin
            send_pixel(dir_table[i].pix);
            // words read straight off the table stand in for the predicted ones
            if (dir_table[i].n_typed != 0) begin
               typed = '{dir_table[i].w0, dir_table[i].w1, dir_table[i].w2};
               repeat (last_pred_n) void'(enc_expected.pop_back());
               for (int k = 0; k < dir_table[i].n_typed; k++) begin
                  enc_expected.push_back(typed[k]);
               end
            end
         end
      end

      // random frames of small sizes under each idling mix
      for (int ph = 0; ph < 4; ph++) begin
         csr_write(CSR_FRAME_WIDTH, DimW'($urandom_range(0, 6)));
         csr_write(CSR_FRAME_HEIGHT, DimW'($urandom_range(0, 3)));
         src_idle_pct = PhaseSrcIdle[ph];
         sink_stall_pct = PhaseSinkStall[ph];
         for (int n = 0; n < RandPerPhase; n++) begin
            // with the sender running flat out, the hold-off backs the encoder up
            if (n == 10 && src_idle_pct == 0) begin
               hold_grants++;
            end
            // size change somewhere in a frame, spare indexes included
            if (n == 20) begin
               csr_write(CsrIndexW'($urandom_range(0, 3)), DimW'($urandom_range(0, 6)));
            end
            // sender pause until every owed word is out
            if (n == 29) begin
               settle_idle();
            end
            // mostly runs of random length, with near-miss and arbitrary colors as noise
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
               pix = prev_pix;
            end else if (roll < 65) begin
               pix = ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000;
            end else if (roll < 80) begin
               pix = prev_pix ^ (PixelW'(1) << $urandom_range(0, PixelW - 1));
            end else begin
               pix = PixelW'($urandom());
            end
            prev_pix = pix;
            send_pixel(pix);
         end
      end

      settle_idle();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("tb_rgb565_run_length_encoder: PASS");
      end else begin
         $display("tb_rgb565_run_length_encoder: FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/rle565_pkg.sv
hdl/rle565_if.sv
hdl/rgb565_run_length_encoder.sv
verif/tb_rgb565_run_length_encoder.sv
